@@ sv/sbd_pkg.sv @@
// sbd_pkg: shared types, constants and helper functions of the SBUS frame decoder.
// Used by every module of the block except sbd_fifo; depends on nothing.
`default_nettype none

package sbd_pkg;

    localparam int FULL_SCALE_DEF = 16384;
    localparam int DATA_W         = 8;
    localparam int CNT_W          = 5;
    localparam int TICK_W         = 16;
    localparam int DB_W           = 15;
    localparam int RAW_W          = 11;
    localparam int STORE_DEPTH    = 24;
    localparam int CHAN_BYTES     = 11;
    localparam int CHAN_W         = CHAN_BYTES * DATA_W;
    localparam int NUM_LANE       = 5;
    localparam int MAG_W          = 25;
    localparam int RECIP_W        = 26;
    localparam int RECIP_S        = 35;
    localparam int Q_W            = 15;
    localparam int VAL_W          = 16;
    localparam int CMD_DEPTH      = 2;
    localparam int RES_DEPTH      = 2;

    localparam logic [CNT_W-1:0]  CNT_LAST_BYTE = CNT_W'(24);
    localparam logic [CNT_W-1:0]  CNT_SAT       = '1;
    localparam logic [DATA_W-1:0] FRAME_HEADER  = 8'h0F;
    localparam logic [DATA_W-1:0] FRAME_FOOTER  = 8'h00;
    localparam int                FLAGS_BYTE    = 23;
    localparam int                FAILSAFE_BIT  = 3;
    localparam logic [TICK_W-1:0] TIMEOUT_RST   = 16'd100;
    localparam logic [DB_W-1:0]   DEADBAND_RST  = 15'd819;

    localparam logic [RAW_W-1:0]   RAW_UP   = 11'd240;
    localparam logic [RAW_W-1:0]   RAW_MID  = 11'd1024;
    localparam logic [RAW_W-1:0]   RAW_DOWN = 11'd1807;
    localparam logic [RECIP_W-1:0] RECIP_M  = 26'd43882170;

    localparam int LANE_CH  [NUM_LANE] = '{0, 1, 2, 3, 6};
    localparam bit LANE_NEG [NUM_LANE] = '{1'b1, 1'b0, 1'b0, 1'b1, 1'b1};
    localparam int SWA_CH = 4;
    localparam int SWB_CH = 5;
    localparam int SWC_CH = 7;

    typedef enum logic [1:0] {
        SW_UP   = 2'd0,
        SW_MID  = 2'd1,
        SW_DOWN = 2'd2,
        SW_ERR  = 2'd3
    } t_sw;

    typedef enum logic {
        OP_BYTE = 1'b0,
        OP_TICK = 1'b1
    } t_op;

    typedef enum logic {
        CFG_TIMEOUT  = 1'b0,
        CFG_DEADBAND = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic              operation;
        logic [DATA_W-1:0] byte_value;
        logic              end_of_buffer;
    } t_item;

    typedef struct packed {
        logic signed [VAL_W-1:0] right_horizontal;
        logic signed [VAL_W-1:0] right_vertical;
        logic signed [VAL_W-1:0] left_vertical;
        logic signed [VAL_W-1:0] left_horizontal;
        logic signed [VAL_W-1:0] knob_a;
        t_sw                     switch_a;
        t_sw                     switch_b;
        t_sw                     switch_c;
        logic                    link_up;
        logic                    protect;
    } t_result;

    typedef struct packed {
        logic              good;
        logic [CHAN_W-1:0] chans;
    } t_cmd;

    function automatic logic [RAW_W-1:0] chan_raw(input logic [CHAN_W-1:0] chans,
                                                  input int ch);
        return chans[RAW_W*ch +: RAW_W];
    endfunction

    function automatic t_sw sw_code(input logic [RAW_W-1:0] raw);
        t_sw code;
        priority if (raw == RAW_UP)   code = SW_UP;
        else if (raw == RAW_MID)      code = SW_MID;
        else if (raw == RAW_DOWN)     code = SW_DOWN;
        else                          code = SW_ERR;
        return code;
    endfunction

endpackage

`default_nettype wire

@@ sv/sbd_fifo.sv @@
// sbd_fifo: small synchronous queue with push/full and pop/empty sides.
// Depends on nothing; the payload type is a parameter.
`default_nettype none

module sbd_fifo #(
    parameter type t_data = logic,
    parameter int  DEPTH  = 2
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  wire t_data i_data,
    output logic       o_full,
    input  wire logic  i_pop,
    output t_data      o_data,
    output logic       o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_data            r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr;
    logic [PW-1:0]    r_rd_ptr;
    logic [CW-1:0]    r_count;
    logic [PW-1:0]    n_wr_ptr;
    logic [PW-1:0]    n_rd_ptr;
    logic             w_push;
    logic             w_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    assign n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
    assign n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= n_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= n_rd_ptr;
            end
            unique case ({w_push, w_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

@@ sv/sbd_front.sv @@
// sbd_front: byte and tick intake, frame store, frame check and timeout counter.
// Emits decode or idle commands. Depends on sbd_pkg.
`default_nettype none

module sbd_front (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_accept,
    input  wire sbd_pkg::t_item        i_item,
    input  wire logic [15:0]           i_timeout,
    output logic                       o_cmd_push,
    output sbd_pkg::t_cmd              o_cmd
);
    import sbd_pkg::*;

    logic [DATA_W-1:0] r_store [STORE_DEPTH];
    logic [CNT_W-1:0]  r_byte_cnt;
    logic [TICK_W-1:0] r_silence;

    logic w_tick;
    logic w_byte;
    logic w_fire;
    logic w_frame;
    logic w_failsafe;

    assign w_tick     = i_accept && (i_item.operation == OP_TICK);
    assign w_byte     = i_accept && (i_item.operation == OP_BYTE);
    assign w_fire     = r_silence >= i_timeout;
    assign w_frame    = w_byte && i_item.end_of_buffer && (r_byte_cnt == CNT_LAST_BYTE)
                        && (i_item.byte_value == FRAME_FOOTER)
                        && (r_store[0] == FRAME_HEADER);
    assign w_failsafe = r_store[FLAGS_BYTE][FAILSAFE_BIT];

    always_comb begin
        for (int k = 0; k < CHAN_BYTES; k++) begin
            o_cmd.chans[DATA_W*k +: DATA_W] = r_store[k + 1];
        end
        o_cmd.good = w_frame && !w_failsafe;
        o_cmd_push = (w_tick && w_fire) || w_frame;
    end

    always_ff @(posedge i_clk) begin
        if (w_byte && (r_byte_cnt < CNT_W'(STORE_DEPTH))) begin
            r_store[r_byte_cnt] <= i_item.byte_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_cnt <= '0;
            r_silence  <= '0;
        end else begin
            if (w_tick && (r_silence != '1)) begin
                r_silence <= r_silence + 1'b1;
            end
            if (w_frame && !w_failsafe) begin
                r_silence <= '0;
            end
            if (w_byte) begin
                if (i_item.end_of_buffer) begin
                    r_byte_cnt <= '0;
                end else if (r_byte_cnt != CNT_SAT) begin
                    r_byte_cnt <= r_byte_cnt + 1'b1;
                end
            end
        end
    end

endmodule

`default_nettype wire

@@ sv/sbd_back.sv @@
// sbd_back: two-stage channel decode pipeline (scale, divide by reciprocal, clamp).
// Consumes commands, produces result items. Depends on sbd_pkg.
`default_nettype none

module sbd_back #(
    parameter int FULL_SCALE = sbd_pkg::FULL_SCALE_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire sbd_pkg::t_cmd         i_cmd,
    input  wire logic                  i_cmd_empty,
    output logic                       o_cmd_pop,
    input  wire logic [14:0]           i_deadband,
    input  wire logic                  i_res_full,
    output logic                       o_res_push,
    output sbd_pkg::t_result           o_result
);
    import sbd_pkg::*;

    localparam logic [Q_W-1:0] FS_Q = Q_W'(FULL_SCALE);

    typedef struct packed {
        logic good;
        t_sw  sa;
        t_sw  sb;
        t_sw  sc;
    } t_ctl;

    logic             r1_valid;
    logic             r2_valid;
    t_ctl             r1_ctl;
    t_ctl             r2_ctl;
    logic [NUM_LANE-1:0] r1_sign;
    logic [NUM_LANE-1:0] r2_sign;
    logic [MAG_W-1:0] r1_mag [NUM_LANE];
    logic [Q_W-1:0]   r2_q   [NUM_LANE];
    t_sw              r_last_sa;

    logic             w_en;
    logic             w_take;
    t_ctl             w_ctl;
    logic [NUM_LANE-1:0] w_sign;
    logic [MAG_W-1:0] w_mag  [NUM_LANE];
    logic [Q_W-1:0]   w_q    [NUM_LANE];
    logic signed [VAL_W-1:0] w_val [NUM_LANE];

    assign w_en       = !(r2_valid && i_res_full);
    assign w_take     = w_en && !i_cmd_empty;
    assign o_cmd_pop  = w_take;
    assign o_res_push = r2_valid && w_en;

    always_comb begin
        logic signed [RAW_W:0] d;
        logic [RAW_W:0]        a;
        w_ctl.good = i_cmd.good;
        w_ctl.sa   = i_cmd.good ? sw_code(chan_raw(i_cmd.chans, SWA_CH)) : r_last_sa;
        w_ctl.sb   = i_cmd.good ? sw_code(chan_raw(i_cmd.chans, SWB_CH)) : SW_ERR;
        w_ctl.sc   = i_cmd.good ? sw_code(chan_raw(i_cmd.chans, SWC_CH)) : SW_ERR;
        for (int l = 0; l < NUM_LANE; l++) begin
            d         = $signed({1'b0, chan_raw(i_cmd.chans, LANE_CH[l])})
                        - $signed({1'b0, RAW_MID});
            a         = d[RAW_W] ? -d : d;
            w_sign[l] = d[RAW_W];
            w_mag[l]  = MAG_W'(a) * MAG_W'(FULL_SCALE);
        end
    end

    always_comb begin
        logic [MAG_W+RECIP_W-1:0] p;
        for (int l = 0; l < NUM_LANE; l++) begin
            p      = (MAG_W+RECIP_W)'(r1_mag[l]) * (MAG_W+RECIP_W)'(RECIP_M);
            w_q[l] = p[RECIP_S +: Q_W];
        end
    end

    always_comb begin
        logic [Q_W-1:0]   m;
        logic [VAL_W-1:0] u;
        for (int l = 0; l < NUM_LANE; l++) begin
            m = (r2_q[l] > FS_Q) ? FS_Q : r2_q[l];
            if ((m < i_deadband) || !r2_ctl.good) begin
                m = '0;
            end
            u = VAL_W'(m);
            w_val[l] = (r2_sign[l] ^ LANE_NEG[l]) ? -$signed(u) : $signed(u);
        end
        o_result.right_horizontal = w_val[0];
        o_result.right_vertical   = w_val[1];
        o_result.left_vertical    = w_val[2];
        o_result.left_horizontal  = w_val[3];
        o_result.knob_a           = w_val[4];
        o_result.switch_a         = r2_ctl.sa;
        o_result.switch_b         = r2_ctl.sb;
        o_result.switch_c         = r2_ctl.sc;
        o_result.link_up          = r2_ctl.good;
        o_result.protect          = !(r2_ctl.good && (r2_ctl.sa == SW_DOWN));
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_ctl  <= w_ctl;
            r1_sign <= w_sign;
            r2_ctl  <= r1_ctl;
            r2_sign <= r1_sign;
            for (int l = 0; l < NUM_LANE; l++) begin
                r1_mag[l] <= w_mag[l];
                r2_q[l]   <= w_q[l];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid  <= 1'b0;
            r2_valid  <= 1'b0;
            r_last_sa <= SW_ERR;
        end else begin
            if (w_en) begin
                r1_valid <= w_take;
                r2_valid <= r1_valid;
            end
            if (w_take && i_cmd.good) begin
                r_last_sa <= w_ctl.sa;
            end
        end
    end

endmodule

`default_nettype wire

@@ sv/sbus_frame_decoder.sv @@
// SBUS frame decoder top level: configuration registers, intake front end,
// command queue, decode pipeline and result queue.
// Depends on sbd_pkg, sbd_fifo, sbd_front and sbd_back.
//
// Usage:
//   Input queue side: drive i_item and raise push while full is low; each
//   transfer is one UART byte (operation 0) or one time tick (operation 1).
//   One item is taken every cycle while the pipeline flows.
//   Result queue side: a result sits on o_result while empty is low; raise
//   pop to take it. Only a decoded frame, a failsafe frame or a timeout
//   tick produces a result.
//   Path: the transfer that causes a result writes the command queue,
//   then passes two decode stages (scale multiply, reciprocal multiply)
//   and the result queue write.
//   Configuration: write timeout_ticks (index 0) or deadband (index 1)
//   through i_cfg_valid / o_cfg_ready while the block is idle.
//   Reset: queues and counters clear, timeout 100, deadband 819, the
//   remembered switch a code is error. Frame bytes need no clearing.
//   Stall: when pop stays low the result queue fills, the pipeline holds,
//   the command queue fills and full rises; nothing is dropped.
`default_nettype none

module sbus_frame_decoder #(
    parameter int FULL_SCALE = sbd_pkg::FULL_SCALE_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  push,
    output logic                       full,
    input  wire sbd_pkg::t_item        i_item,
    output logic                       empty,
    input  wire logic                  pop,
    output sbd_pkg::t_result           o_result,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire sbd_pkg::t_cfg_idx     i_cfg_index,
    input  wire logic [15:0]           i_cfg_data
);
    import sbd_pkg::*;

    logic [TICK_W-1:0] r_timeout;
    logic [DB_W-1:0]   r_deadband;

    logic    w_accept;
    logic    w_cmd_push;
    t_cmd    w_cmd_in;
    t_cmd    w_cmd_out;
    logic    w_cmd_empty;
    logic    w_cmd_pop;
    logic    w_res_push;
    logic    w_res_full;
    t_result w_res_in;

    assign o_cfg_ready = 1'b1;
    assign w_accept    = push && !full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout  <= TIMEOUT_RST;
            r_deadband <= DEADBAND_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_TIMEOUT:  r_timeout  <= i_cfg_data;
                CFG_DEADBAND: r_deadband <= i_cfg_data[DB_W-1:0];
            endcase
        end
    end

    sbd_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (w_accept),
        .i_item     (i_item),
        .i_timeout  (r_timeout),
        .o_cmd_push (w_cmd_push),
        .o_cmd      (w_cmd_in)
    );

    sbd_fifo #(
        .t_data (t_cmd),
        .DEPTH  (CMD_DEPTH)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_cmd_push),
        .i_data  (w_cmd_in),
        .o_full  (full),
        .i_pop   (w_cmd_pop),
        .o_data  (w_cmd_out),
        .o_empty (w_cmd_empty)
    );

    sbd_back #(
        .FULL_SCALE (FULL_SCALE)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd_out),
        .i_cmd_empty (w_cmd_empty),
        .o_cmd_pop   (w_cmd_pop),
        .i_deadband  (r_deadband),
        .i_res_full  (w_res_full),
        .o_res_push  (w_res_push),
        .o_result    (w_res_in)
    );

    sbd_fifo #(
        .t_data (t_result),
        .DEPTH  (RES_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push),
        .i_data  (w_res_in),
        .o_full  (w_res_full),
        .i_pop   (pop),
        .o_data  (o_result),
        .o_empty (empty)
    );

endmodule

`default_nettype wire
